// ===== src/euler_to_quaternion_macros.svh =====
// Assertion macros shared by the euler_to_quaternion RTL.
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define EQ_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("euler_to_quaternion: assertion failed");

// next-cycle implication
`define EQ_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("euler_to_quaternion: assertion failed");

`endif

// ===== src/eq_pkg.sv =====
// Types, constants and helpers for the Euler angle to quaternion converter.
package eq_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 15;
    localparam int QW           = FRAC_BITS + 1;
    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_FRAC  = 30;
    localparam int CW           = 33;               // CORDIC x/y, Q2.30 plus headroom
    localparam int ZW           = 34;               // CORDIC residual phase
    localparam int SATW         = CW + 1;           // widest value fed to saturation
    localparam int RND_SH       = CORDIC_FRAC - FRAC_BITS;
    localparam int LANE_STAGES  = CORDIC_ITERS + 2;
    localparam int MERGE_STAGES = 3;
    localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

    localparam logic signed [CW-1:0] GAIN_INV = CW'(652032874);

    localparam logic signed [SATW-1:0] SAT_HI = SATW'(2**FRAC_BITS - 1);
    localparam logic signed [SATW-1:0] SAT_LO = SATW'(-(2**FRAC_BITS));

    // atan(2^-i) with 2^32 = 2*pi
    localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef logic signed [ANGLE_BITS-1:0] t_angle;
    typedef logic signed [QW-1:0]         t_q;

    typedef struct packed {
        t_angle roll_angle;
        t_angle pitch_angle;
        t_angle yaw_angle;
    } t_eq_in;

    typedef struct packed {
        t_q quat_w;
        t_q quat_x;
        t_q quat_y;
        t_q quat_z;
    } t_eq_out;

    typedef struct packed {
        t_q c;
        t_q s;
    } t_cs;

    function automatic t_q sat_q(input logic signed [SATW-1:0] v);
        if (v > SAT_HI) return t_q'(SAT_HI);
        if (v < SAT_LO) return t_q'(SAT_LO);
        return t_q'(v);
    endfunction

endpackage

// ===== src/euler_to_quaternion.sv =====
// Top level: ZYX Euler angles to Q1.15 quaternion, three CORDIC lanes and a merge.
// An accepted beat passes the lane stages, then the merge stages, then the output register to o_valid.
// Throughput: one beat per cycle; the whole pipe advances together and a one-beat skid
// register behind the output register absorbs a stall, so o_ready drops only when it is full.
// Reset: synchronous active-low i_rst_n clears the valid bits and the skid; no data reset.
`include "euler_to_quaternion_macros.svh"

module euler_to_quaternion (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  eq_pkg::t_eq_in  i_angles,
    output logic            o_valid,
    input  logic            i_ready,
    output eq_pkg::t_eq_out o_quat
);
    import eq_pkg::*;

    logic [PIPE_STAGES-1:0] r_valid, n_valid;
    logic                   r_out_v, n_out_v;
    logic                   r_skid_v, n_skid_v;
    t_eq_out                r_out, r_skid;
    t_eq_out                w_quat;
    t_cs                    w_roll, w_pitch, w_yaw;
    logic                   w_en;
    logic                   w_present;
    logic                   w_out_free;
    logic                   w_load_out;
    logic                   w_out_from_skid;
    logic                   w_load_skid;

    assign w_en    = !r_skid_v;
    assign o_ready = w_en;

    eq_cordic_lane u_roll (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(i_angles.roll_angle),
        .o_cs   (w_roll)
    );

    eq_cordic_lane u_pitch (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(i_angles.pitch_angle),
        .o_cs   (w_pitch)
    );

    eq_cordic_lane u_yaw (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(i_angles.yaw_angle),
        .o_cs   (w_yaw)
    );

    eq_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_roll (w_roll),
        .i_pitch(w_pitch),
        .i_yaw  (w_yaw),
        .o_quat (w_quat)
    );

    assign n_valid   = w_en ? {r_valid[PIPE_STAGES-2:0], i_valid} : r_valid;
    assign w_present = w_en && r_valid[PIPE_STAGES-1];

    // output register plus skid: a finished beat always has somewhere to land
    always_comb begin
        n_out_v         = r_out_v;
        n_skid_v        = r_skid_v;
        w_load_out      = 1'b0;
        w_out_from_skid = 1'b0;
        w_load_skid     = 1'b0;
        w_out_free      = !r_out_v || i_ready;
        priority if (r_skid_v) begin
            if (w_out_free) begin
                n_out_v         = 1'b1;
                n_skid_v        = 1'b0;
                w_load_out      = 1'b1;
                w_out_from_skid = 1'b1;
            end
        end else if (w_present) begin
            if (w_out_free) begin
                n_out_v    = 1'b1;
                w_load_out = 1'b1;
            end else begin
                n_skid_v    = 1'b1;
                w_load_skid = 1'b1;
            end
        end else begin
            if (w_out_free) begin
                n_out_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= w_out_from_skid ? r_skid : w_quat;
        end
        if (w_load_skid) begin
            r_skid <= w_quat;
        end
    end

    assign o_valid = r_out_v;
    assign o_quat  = r_out;

    `EQ_ASSERT_IMP(a_skid_needs_out, r_skid_v, r_out_v)
    `EQ_ASSERT_NXT(a_skid_holds, r_skid_v && !i_ready, r_skid_v)
    `EQ_ASSERT_NXT(a_accept_enters, i_valid && o_ready, r_valid[0])
    `EQ_ASSERT_NXT(a_done_to_out, r_valid[PIPE_STAGES-1] && o_ready && (!o_valid || i_ready), o_valid)

endmodule

// ===== src/eq_cordic_lane.sv =====
// One lane: pipelined rotation CORDIC giving cos/sin of half a binary angle.
module eq_cordic_lane (
    input  logic           i_clk,
    input  logic           i_en,
    input  eq_pkg::t_angle i_angle,
    output eq_pkg::t_cs    o_cs
);
    import eq_pkg::*;

    logic signed [CW-1:0] w_x [0:CORDIC_ITERS];
    logic signed [CW-1:0] w_y [0:CORDIC_ITERS];
    logic signed [ZW-1:0] w_z [0:CORDIC_ITERS];

    logic signed [31:0]   w_phase;
    logic signed [ZW-1:0] r_z0;
    logic signed [CW:0]   w_xr;
    logic signed [CW:0]   w_yr;
    t_cs                  r_cs;

    // angle scaled to a 32-bit phase, then halved
    assign w_phase = {i_angle, {(32 - ANGLE_BITS){1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z0 <= ZW'(w_phase >>> 1);
        end
    end

    assign w_x[0] = GAIN_INV;
    assign w_y[0] = '0;
    assign w_z[0] = r_z0;

    for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
        logic signed [CW-1:0] w_dx;
        logic signed [CW-1:0] w_dy;
        logic signed [ZW-1:0] w_at;
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [ZW-1:0] n_z;
        logic signed [CW-1:0] r_x;
        logic signed [CW-1:0] r_y;
        logic signed [ZW-1:0] r_z;

        assign w_dx = w_y[i] >>> i;
        assign w_dy = w_x[i] >>> i;
        assign w_at = $signed({{(ZW - 32){1'b0}}, ATAN_TAB[i]});

        always_comb begin
            if (!w_z[i][ZW-1]) begin
                n_x = w_x[i] - w_dx;
                n_y = w_y[i] + w_dy;
                n_z = w_z[i] - w_at;
            end else begin
                n_x = w_x[i] + w_dx;
                n_y = w_y[i] - w_dy;
                n_z = w_z[i] + w_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
            end
        end

        assign w_x[i+1] = r_x;
        assign w_y[i+1] = r_y;
        assign w_z[i+1] = r_z;
    end

    // round half up to Q1.FRAC_BITS
    assign w_xr = (CW + 1)'(w_x[CORDIC_ITERS]) + (CW + 1)'(2**(RND_SH - 1));
    assign w_yr = (CW + 1)'(w_y[CORDIC_ITERS]) + (CW + 1)'(2**(RND_SH - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cs.c <= sat_q(SATW'(w_xr >>> RND_SH));
            r_cs.s <= sat_q(SATW'(w_yr >>> RND_SH));
        end
    end

    assign o_cs = r_cs;

endmodule

// ===== src/eq_merge.sv =====
// Merge stage: combines the three lanes' cos/sin into the ZYX quaternion.
module eq_merge (
    input  logic            i_clk,
    input  logic            i_en,
    input  eq_pkg::t_cs     i_roll,
    input  eq_pkg::t_cs     i_pitch,
    input  eq_pkg::t_cs     i_yaw,
    output eq_pkg::t_eq_out o_quat
);
    import eq_pkg::*;

    localparam int P1W = 2 * QW + 1;
    localparam int P2W = 2 * QW + 2;

    function automatic logic signed [QW:0] rmul1(input t_q a, input t_q b);
        logic signed [P1W-1:0] p;
        p = P1W'(a) * P1W'(b) + P1W'(2**(FRAC_BITS - 1));
        return (QW + 1)'(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [QW+1:0] rmul2(input logic signed [QW:0] a, input t_q b);
        logic signed [P2W-1:0] p;
        p = P2W'(a) * P2W'(b) + P2W'(2**(FRAC_BITS - 1));
        return (QW + 2)'(p >>> FRAC_BITS);
    endfunction

    logic signed [QW:0]   r_cc, r_ss, r_sc, r_cs;
    t_q                   r_cy, r_sy;
    logic signed [QW+1:0] r_wa, r_wb, r_xa, r_xb, r_ya, r_yb, r_za, r_zb;
    t_eq_out              r_quat;

    // first products: roll by pitch
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc <= rmul1(i_roll.c, i_pitch.c);
            r_ss <= rmul1(i_roll.s, i_pitch.s);
            r_sc <= rmul1(i_roll.s, i_pitch.c);
            r_cs <= rmul1(i_roll.c, i_pitch.s);
            r_cy <= i_yaw.c;
            r_sy <= i_yaw.s;
        end
    end

    // second products: by yaw
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wa <= rmul2(r_cc, r_cy);
            r_wb <= rmul2(r_ss, r_sy);
            r_xa <= rmul2(r_sc, r_cy);
            r_xb <= rmul2(r_cs, r_sy);
            r_ya <= rmul2(r_cs, r_cy);
            r_yb <= rmul2(r_sc, r_sy);
            r_za <= rmul2(r_cc, r_sy);
            r_zb <= rmul2(r_ss, r_cy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quat.quat_w <= sat_q(SATW'(r_wa) + SATW'(r_wb));
            r_quat.quat_x <= sat_q(SATW'(r_xa) - SATW'(r_xb));
            r_quat.quat_y <= sat_q(SATW'(r_ya) + SATW'(r_yb));
            r_quat.quat_z <= sat_q(SATW'(r_za) - SATW'(r_zb));
        end
    end

    assign o_quat = r_quat;

endmodule

// ===== bench/tb_euler_to_quaternion.sv =====
// Testbench for euler_to_quaternion: directed table, random angles, ready/valid stalls.
`timescale 1ns / 1ps

module tb_euler_to_quaternion;
    import eq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int TAIL_CYCLES    = 40;
    localparam int N_DIR          = 20;
    localparam int N_PHASES       = 5;

    // atan(2^-i), 2^32 = 2*pi
    localparam longint ATAN_PHASE [30] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051,
        'h00000029, 'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
    };
    localparam longint INV_GAIN = 652032874;

    typedef struct packed {
        t_eq_in  ang;
        logic    known;
        t_eq_out quat;
    } t_dir_row;

    // roll, pitch, yaw; quaternion typed only where obvious
    localparam t_dir_row DIR_TAB [N_DIR] = '{
        {16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 16'sd32765, 16'sd0, 16'sd0, 16'sd0},
        {16'sh8000, 16'sh0000, 16'sh0000, 1'b0, 64'h0},
        {16'sh0000, 16'sh8000, 16'sh0000, 1'b0, 64'h0},
        {16'sh0000, 16'sh0000, 16'sh8000, 1'b0, 64'h0},
        {16'sh7FFF, 16'sh0000, 16'sh0000, 1'b0, 64'h0},
        {16'sh0000, 16'sh7FFF, 16'sh0000, 1'b0, 64'h0},
        {16'sh0000, 16'sh0000, 16'sh7FFF, 1'b0, 64'h0},
        {16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 64'h0},
        {16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 64'h0},
        {16'sh0001, 16'shFFFF, 16'sh0001, 1'b0, 64'h0},
        {16'shFFFF, 16'sh0001, 16'shFFFF, 1'b0, 64'h0},
        {16'sh4000, 16'sh0000, 16'shC000, 1'b0, 64'h0},
        {16'shC000, 16'sh4000, 16'sh0000, 1'b0, 64'h0},
        {16'sh2000, 16'sh2000, 16'sh2000, 1'b0, 64'h0},
        {16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, 64'h0},
        {16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, 64'h0},
        {16'sh8000, 16'sh7FFF, 16'sh8001, 1'b0, 64'h0},
        {16'sh8001, 16'sh8000, 16'sh7FFF, 1'b0, 64'h0},
        {16'sh1234, 16'shEDCB, 16'sh7000, 1'b0, 64'h0},
        {16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 16'sd32765, 16'sd0, 16'sd0, 16'sd0}
    };

    localparam t_angle CORNER_ANGLES [8] = '{
        16'sh8000, 16'sh8001, 16'shFFFF, 16'sh0000,
        16'sh0001, 16'sh4000, 16'shC000, 16'sh7FFF
    };

    // sender idle %, receiver stall %, beats, long receiver hold-off
    localparam int PHASE_SEND [N_PHASES]  = '{0, 78, 0, 20, 0};
    localparam int PHASE_RECV [N_PHASES]  = '{0, 0, 78, 20, 0};
    localparam int PHASE_BEATS [N_PHASES] = '{200, 200, 200, 200, 60};
    localparam bit PHASE_HOLD [N_PHASES]  = '{0, 0, 0, 0, 1};

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_ready;
    t_eq_in  i_angles;
    logic    o_valid;
    logic    i_ready;
    t_eq_out o_quat;

    t_eq_out quat_expect_q [$];
    int      err_cnt;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_req;
    int      quiet_cycles;

    euler_to_quaternion DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_angles (i_angles),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_quat   (o_quat)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint clamp_q15(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint q15_mul(input longint a, input longint b);
        return (a * b + 16384) >>> 15;
    endfunction

    // cos/sin of half the binary angle, CORDIC in Q2.30, rounded to Q1.15
    function automatic void half_angle_cs(input t_angle a, output longint c, output longint s);
        longint z, x, y, dx, dy;
        z = longint'(a) * 32768;
        x = INV_GAIN;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_PHASE[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_PHASE[i];
            end
        end
        c = clamp_q15((x + 16384) >>> 15);
        s = clamp_q15((y + 16384) >>> 15);
    endfunction

    function automatic t_eq_out predict_quat(input t_eq_in a);
        longint cr, sr, cp, sp, cy, sy;
        t_eq_out q;
        half_angle_cs(a.roll_angle, cr, sr);
        half_angle_cs(a.pitch_angle, cp, sp);
        half_angle_cs(a.yaw_angle, cy, sy);
        q.quat_w = 16'(clamp_q15(q15_mul(q15_mul(cr, cp), cy) + q15_mul(q15_mul(sr, sp), sy)));
        q.quat_x = 16'(clamp_q15(q15_mul(q15_mul(sr, cp), cy) - q15_mul(q15_mul(cr, sp), sy)));
        q.quat_y = 16'(clamp_q15(q15_mul(q15_mul(cr, sp), cy) + q15_mul(q15_mul(sr, cp), sy)));
        q.quat_z = 16'(clamp_q15(q15_mul(q15_mul(cr, cp), sy) - q15_mul(q15_mul(sr, sp), cy)));
        return q;
    endfunction

    function automatic t_angle rand_angle();
        if ($urandom_range(3) == 0)
            return CORNER_ANGLES[$urandom_range(7)];
        return t_angle'($urandom_range(65535));
    endfunction

    task automatic check_field(input string name, input t_q exp_v, input t_q act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // drive one beat from a falling edge, return at the falling edge after acceptance
    task automatic send_angles(input t_eq_in a, input logic known, input t_eq_out quat);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_angles <= a;
        do @(posedge i_clk); while (!o_ready);
        quat_expect_q.push_back(known ? quat : predict_quat(a));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (quat_expect_q.size() != 0) @(negedge i_clk);
    endtask

    // receiver
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                end
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin : result_chk
        t_eq_out exp_q;
        if (i_rst_n && o_valid && i_ready) begin
            if (quat_expect_q.size() == 0) begin
                $display("%0t: unexpected result, got %h", $time, o_quat);
                err_cnt++;
            end else begin
                exp_q = quat_expect_q.pop_front();
                check_field("quat_w", exp_q.quat_w, o_quat.quat_w);
                check_field("quat_x", exp_q.quat_x, o_quat.quat_x);
                check_field("quat_y", exp_q.quat_y, o_quat.quat_y);
                check_field("quat_z", exp_q.quat_z, o_quat.quat_z);
            end
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, %0d results outstanding", $time, quat_expect_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin : stim
        t_eq_in ang;
        err_cnt        = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_angles <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIR_TAB[r])
            send_angles(DIR_TAB[r].ang, DIR_TAB[r].known, DIR_TAB[r].quat);
        i_valid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct  = PHASE_SEND[ph];
            recv_stall_pct = PHASE_RECV[ph];
            // hold-off fills the pipe and the skid, so o_ready must drop
            if (PHASE_HOLD[ph])
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_BEATS[ph]; n++) begin
                ang.roll_angle  = rand_angle();
                ang.pitch_angle = rand_angle();
                ang.yaw_angle   = rand_angle();
                send_angles(ang, 1'b0, '0);
            end
            i_valid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
